// File: rtl/pfb_pkg.sv
// pfb_pkg: shared types and constants of the page frame buffer draw engine.
// Used by pfb_front, pfb_cmd_fifo, pfb_back and the top level. No dependencies.

package pfb_pkg;

    // input command codes
    localparam logic [1:0] CMD_FILL = 2'd0;
    localparam logic [1:0] CMD_RECT = 2'd1;
    localparam logic [1:0] CMD_BLIT = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    // configuration register indexes
    localparam int          CFG_INDEX_W = 4;
    localparam logic [3:0]  REG_COLUMNS = 4'd0;
    localparam logic [3:0]  REG_PAGES   = 4'd1;

    localparam logic [7:0]  COLUMNS_RESET = 8'd128;
    localparam logic [3:0]  PAGES_RESET   = 4'd8;

    // column and page index widths cover the largest supported store
    localparam int COL_IDX_W  = 8;
    localparam int PAGE_IDX_W = 4;

    localparam int FIFO_DEPTH = 2;

    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ERR,
        OP_FILL,
        OP_RECT,
        OP_BLIT,
        OP_READ
    } op_t;

    // classified request handed from front to back
    typedef struct packed {
        op_t                   op;
        logic                  rmw;      // read-modify-write per byte
        logic                  set_or;   // rmw: OR bits in, else clear them
        logic [COL_IDX_W-1:0]  col_first;
        logic [COL_IDX_W-1:0]  col_last;
        logic [PAGE_IDX_W-1:0] page_first;
        logic [PAGE_IDX_W-1:0] page_last;
        logic [2:0]            y_lo;     // row within first page
        logic [2:0]            y_hi;     // row within last page
        logic [7:0]            data;     // fill byte, blit byte or low blit part
        logic [7:0]            data_hi;  // blit spill into next page
    } cmd_t;

endpackage

// File: rtl/pfb_front.sv
// pfb_front: configuration registers, input acceptance and request classification.
// Depends on pfb_pkg.

module pfb_front #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_PAGES   = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [6:0]                    s_x_first,
    input  logic [6:0]                    s_x_last,
    input  logic [5:0]                    s_y_first,
    input  logic [5:0]                    s_y_last,
    input  logic                          s_set_bits,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_invert,
    input  logic                          fifo_full,
    input  logic                          init_busy,
    output logic                          push,
    output pfb_pkg::cmd_t                 push_cmd
);

    logic [7:0]  columns_reg, columns_next;
    logic [3:0]  pages_reg, pages_next;
    logic [8:0]  eff_cols;
    logic [4:0]  eff_pages;
    logic [7:0]  rows;
    logic        x1_ok, x2_ok, y1_ok, y2_ok;
    logic [7:0]  img;
    logic [15:0] img_sh;
    logic [4:0]  next_page;
    pfb_pkg::cmd_t c;

    assign cfg_ready = 1'b1;
    assign s_ready   = !fifo_full && !init_busy;
    assign push      = s_valid && s_ready;
    assign push_cmd  = c;

    always_comb begin
        columns_next = columns_reg;
        pages_next   = pages_reg;
        if (cfg_valid) begin
            if (cfg_index == pfb_pkg::REG_COLUMNS) begin
                columns_next = cfg_data;
            end else if (cfg_index == pfb_pkg::REG_PAGES) begin
                pages_next = cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= pfb_pkg::COLUMNS_RESET;
            pages_reg   <= pfb_pkg::PAGES_RESET;
        end else begin
            columns_reg <= columns_next;
            pages_reg   <= pages_next;
        end
    end

    always_comb begin
        eff_cols  = ({1'b0, columns_reg} > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS)
                                                            : {1'b0, columns_reg};
        eff_pages = ({1'b0, pages_reg} > 5'(MAX_PAGES)) ? 5'(MAX_PAGES) : {1'b0, pages_reg};
        rows      = {eff_pages, 3'b000};
        x1_ok     = {2'b00, s_x_first} < eff_cols;
        x2_ok     = {2'b00, s_x_last} < eff_cols;
        y1_ok     = {2'b00, s_y_first} < rows;
        y2_ok     = {2'b00, s_y_last} < rows;
        img       = s_invert ? ~s_data_byte : s_data_byte;
        img_sh    = {8'h00, img} << s_y_first[2:0];
        next_page = {2'b00, s_y_first[5:3]} + 5'd1;

        c            = '0;
        c.op         = pfb_pkg::OP_NOP;
        c.col_first  = {1'b0, s_x_first};
        c.col_last   = {1'b0, s_x_last};
        c.page_first = {1'b0, s_y_first[5:3]};
        c.page_last  = {1'b0, s_y_last[5:3]};
        c.y_lo       = s_y_first[2:0];
        c.y_hi       = s_y_last[2:0];
        c.set_or     = s_set_bits;

        case (s_command)
            pfb_pkg::CMD_FILL: begin
                if (eff_cols != 9'd0 && eff_pages != 5'd0) begin
                    c.op         = pfb_pkg::OP_FILL;
                    c.col_first  = '0;
                    c.col_last   = 8'(eff_cols - 9'd1);
                    c.page_first = '0;
                    c.page_last  = 4'(eff_pages - 5'd1);
                    c.data       = s_set_bits ? pfb_pkg::BYTE_ONES : pfb_pkg::BYTE_ZEROS;
                end
            end
            pfb_pkg::CMD_RECT: begin
                if (!x1_ok || !x2_ok || !y1_ok || !y2_ok
                        || s_x_first > s_x_last || s_y_first > s_y_last) begin
                    c.op = pfb_pkg::OP_ERR;
                end else begin
                    c.op  = pfb_pkg::OP_RECT;
                    c.rmw = 1'b1;
                end
            end
            pfb_pkg::CMD_BLIT: begin
                c.col_last = {1'b0, s_x_first};
                if (!x1_ok || !y1_ok) begin
                    c.op = pfb_pkg::OP_ERR;
                end else begin
                    c.op        = pfb_pkg::OP_BLIT;
                    c.page_last = {1'b0, s_y_first[5:3]};
                    c.data      = img_sh[7:0];
                    c.data_hi   = img_sh[15:8];
                    if (s_y_first[2:0] != 3'd0) begin
                        // unaligned: OR the two parts, spill dropped past last page
                        c.rmw    = 1'b1;
                        c.set_or = 1'b1;
                        if (next_page < eff_pages) begin
                            c.page_last = next_page[3:0];
                        end
                    end
                end
            end
            pfb_pkg::CMD_READ: begin
                c.col_last  = {1'b0, s_x_first};
                c.page_last = {1'b0, s_y_first[5:3]};
                c.op        = (!x1_ok || !y1_ok) ? pfb_pkg::OP_ERR : pfb_pkg::OP_READ;
            end
            default: begin
                c.op = pfb_pkg::OP_ERR;
            end
        endcase
    end

endmodule

// File: rtl/pfb_cmd_fifo.sv
// pfb_cmd_fifo: short queue of classified requests between front and back.
// Depends on pfb_pkg.

module pfb_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pfb_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output pfb_pkg::cmd_t head
);

    localparam int PTR_W = $clog2(pfb_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(pfb_pkg::FIFO_DEPTH + 1);

    pfb_pkg::cmd_t entry_reg [pfb_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == CNT_W'(pfb_pkg::FIFO_DEPTH);
    assign valid   = count_reg != '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(pfb_pkg::FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/pfb_back.sv
// pfb_back: frame store memory, post-reset clearing sweep, byte sequencer and result register.
// Depends on pfb_pkg.

module pfb_back #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_PAGES   = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fifo_valid,
    input  pfb_pkg::cmd_t fifo_head,
    output logic          pop,
    output logic          init_busy,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_status,
    output logic [7:0]    m_read_data
);

    localparam int DEPTH  = MAX_PAGES * MAX_COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } state_t;

    logic [7:0] mem [DEPTH];
    logic [7:0] mem_q_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;

    state_t state_reg, state_next;
    pfb_pkg::cmd_t cmd_reg, cmd_next;
    logic [ADDR_W-1:0]              init_cnt_reg, init_cnt_next;
    logic [pfb_pkg::PAGE_IDX_W-1:0] page_reg, page_next;
    logic [pfb_pkg::COL_IDX_W-1:0]  col_reg, col_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]        pend_bits_reg, pend_bits_next;
    logic              pend_or_reg, pend_or_next;
    logic              res_status_reg, res_status_next;
    logic [7:0]        res_data_reg, res_data_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_status_reg, m_status_next;
    logic [7:0]        m_read_data_reg, m_read_data_next;

    logic [ADDR_W-1:0] cur_addr;
    logic [2:0]        lo, hi;
    logic [7:0]        bits;
    logic              last_col, last_page;

    assign init_busy   = state_reg == S_INIT;
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_read_data = m_read_data_reg;

    always_comb begin
        cur_addr  = ADDR_W'(int'(page_reg) * MAX_COLUMNS + int'(col_reg));
        last_col  = col_reg == cmd_reg.col_last;
        last_page = page_reg == cmd_reg.page_last;
        lo = (page_reg == cmd_reg.page_first) ? cmd_reg.y_lo : 3'd0;
        hi = last_page ? cmd_reg.y_hi : 3'd7;
        if (cmd_reg.op == pfb_pkg::OP_RECT) begin
            bits = (pfb_pkg::BYTE_ONES << lo) & (pfb_pkg::BYTE_ONES >> (3'd7 - hi));
        end else if (cmd_reg.op == pfb_pkg::OP_BLIT && page_reg != cmd_reg.page_first) begin
            bits = cmd_reg.data_hi;
        end else begin
            bits = cmd_reg.data;
        end
    end

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        init_cnt_next    = init_cnt_reg;
        page_next        = page_reg;
        col_next         = col_reg;
        pend_valid_next  = 1'b0;
        pend_addr_next   = pend_addr_reg;
        pend_bits_next   = pend_bits_reg;
        pend_or_next     = pend_or_reg;
        res_status_next  = res_status_reg;
        res_data_next    = res_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_read_data_next = m_read_data_reg;
        pop              = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = cur_addr;
        mem_wdata        = bits;
        mem_raddr        = cur_addr;

        // second half of a read-modify-write: read data arrived this cycle
        if (pend_valid_reg) begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = pend_or_reg ? (mem_q_reg | pend_bits_reg)
                                    : (mem_q_reg & ~pend_bits_reg);
        end

        case (state_reg)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = init_cnt_reg;
                mem_wdata = pfb_pkg::BYTE_ZEROS;
                if (init_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    init_cnt_next = init_cnt_reg + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (fifo_valid) begin
                    pop             = 1'b1;
                    cmd_next        = fifo_head;
                    page_next       = fifo_head.page_first;
                    col_next        = fifo_head.col_first;
                    res_status_next = fifo_head.op == pfb_pkg::OP_ERR;
                    res_data_next   = '0;
                    if (fifo_head.op == pfb_pkg::OP_ERR || fifo_head.op == pfb_pkg::OP_NOP) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (cmd_reg.rmw) begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = cur_addr;
                    pend_bits_next  = bits;
                    pend_or_next    = cmd_reg.set_or;
                end else if (cmd_reg.op != pfb_pkg::OP_READ) begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_addr;
                    mem_wdata = bits;
                end
                if (last_col) begin
                    col_next = cmd_reg.col_first;
                    if (last_page) begin
                        state_next = S_DRAIN;
                    end else begin
                        page_next = page_reg + (pfb_pkg::PAGE_IDX_W)'(1);
                    end
                end else begin
                    col_next = col_reg + (pfb_pkg::COL_IDX_W)'(1);
                end
            end
            S_DRAIN: begin
                if (cmd_reg.op == pfb_pkg::OP_READ) begin
                    res_data_next = mem_q_reg;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = res_status_reg;
                    m_read_data_next = res_data_reg;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            init_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            init_cnt_reg   <= init_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        cmd_reg         <= cmd_next;
        page_reg        <= page_next;
        col_reg         <= col_next;
        pend_addr_reg   <= pend_addr_next;
        pend_bits_reg   <= pend_bits_next;
        pend_or_reg     <= pend_or_next;
        res_status_reg  <= res_status_next;
        res_data_reg    <= res_data_next;
        m_status_reg    <= m_status_next;
        m_read_data_reg <= m_read_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_raddr];
    end

endmodule

// File: rtl/page_frame_buffer_draw_engine_core.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// s         in         s_valid / s_ready      command, coordinates, set_bits, data_byte, invert
// m         out        m_valid / m_ready      status, read_data
//
// Each request goes from IDLE through RUN, over each byte touched (pages x columns of the
// rectangle or in-use area; 1 or 2 for a blit, 1 for a read), then DRAIN and DONE;
// errors and a fill with no in-use area go from IDLE straight to DONE.
// The frame store has one port pair (one write, one registered read).
// After reset the store is swept to zero with s_ready low.
// A two-entry request queue keeps s_ready up while a result waits on m_ready, until it is full.
//
// Top level of the page frame buffer draw engine. Depends on pfb_pkg, pfb_front,
// pfb_cmd_fifo and pfb_back.

module page_frame_buffer_draw_engine_core #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_PAGES   = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pfb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_command,
    input  logic [6:0]                      s_x_first,
    input  logic [6:0]                      s_x_last,
    input  logic [5:0]                      s_y_first,
    input  logic [5:0]                      s_y_last,
    input  logic                            s_set_bits,
    input  logic [7:0]                      s_data_byte,
    input  logic                            s_invert,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_status,
    output logic [7:0]                      m_read_data
);

    logic          push, fifo_full, fifo_valid, pop, init_busy;
    pfb_pkg::cmd_t push_cmd, fifo_head;

    pfb_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_PAGES   (MAX_PAGES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_x_first   (s_x_first),
        .s_x_last    (s_x_last),
        .s_y_first   (s_y_first),
        .s_y_last    (s_y_last),
        .s_set_bits  (s_set_bits),
        .s_data_byte (s_data_byte),
        .s_invert    (s_invert),
        .fifo_full   (fifo_full),
        .init_busy   (init_busy),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    pfb_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .valid    (fifo_valid),
        .head     (fifo_head)
    );

    pfb_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_PAGES   (MAX_PAGES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fifo_valid  (fifo_valid),
        .fifo_head   (fifo_head),
        .pop         (pop),
        .init_busy   (init_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_read_data (m_read_data)
    );

endmodule

// File: bench/page_frame_buffer_draw_engine_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for page_frame_buffer_draw_engine_core: queued draw/read requests,
// a local frame store model predicts status and read data, every result is checked in order.
// Depends on pfb_pkg and the draw engine RTL.

module page_frame_buffer_draw_engine_core_tb;

    localparam int NUM_COLS     = 128;
    localparam int NUM_PAGES    = 8;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 32;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 56;

    // indexes with no register behind them
    localparam logic [pfb_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO = 4'd7;
    localparam logic [pfb_pkg::CFG_INDEX_W-1:0] REG_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] x_first;
        logic [6:0] x_last;
        logic [5:0] y_first;
        logic [5:0] y_last;
        logic       set_bits;
        logic [7:0] data_byte;
        logic       invert;
    } draw_req_t;

    typedef struct packed {
        logic       status;
        logic [7:0] read_data;
    } draw_rsp_t;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_valid   = 1'b0;
    logic                            cfg_ready;
    logic [pfb_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [7:0]                      cfg_data    = '0;
    logic                            s_valid     = 1'b0;
    logic                            s_ready;
    logic [1:0]                      s_command   = '0;
    logic [6:0]                      s_x_first   = '0;
    logic [6:0]                      s_x_last    = '0;
    logic [5:0]                      s_y_first   = '0;
    logic [5:0]                      s_y_last    = '0;
    logic                            s_set_bits  = 1'b0;
    logic [7:0]                      s_data_byte = '0;
    logic                            s_invert    = 1'b0;
    logic                            m_valid;
    logic                            m_ready     = 1'b0;
    logic                            m_status;
    logic [7:0]                      m_read_data;

    // model of the frame store and its registers
    logic [7:0] store_model [NUM_COLS*NUM_PAGES];
    logic [7:0] cols_reg  = pfb_pkg::COLUMNS_RESET;
    logic [3:0] pages_reg = pfb_pkg::PAGES_RESET;

    draw_req_t pending_reqs[$];
    draw_rsp_t expected_rsps[$];
    draw_req_t cur_req;

    int          errors        = 0;
    int          reqs_sent     = 0;
    int          rsps_checked  = 0;
    int          settings_used = 0;
    bit          s_burst       = 1'b0;
    bit          m_burst       = 1'b0;
    int unsigned s_gap         = 0;
    int unsigned m_stall       = 0;
    int unsigned idle_cycles   = 0;

    page_frame_buffer_draw_engine_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_x_first   (s_x_first),
        .s_x_last    (s_x_last),
        .s_y_first   (s_y_first),
        .s_y_last    (s_y_last),
        .s_set_bits  (s_set_bits),
        .s_data_byte (s_data_byte),
        .s_invert    (s_invert),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_read_data (m_read_data)
    );

    always #10 aclk = ~aclk;

    function automatic int eff_cols();
        return (cols_reg > NUM_COLS) ? NUM_COLS : int'(cols_reg);
    endfunction

    function automatic int eff_pages();
        return (pages_reg > NUM_PAGES) ? NUM_PAGES : int'(pages_reg);
    endfunction

    // applies one request to the store model and returns the result it should give
    function automatic draw_rsp_t apply_draw_req(input draw_req_t r);
        draw_rsp_t  rsp;
        int         cols, pages, rows, p, c, y, page, off, idx;
        logic [7:0] img, row_bit;
        logic [15:0] shifted;
        rsp.status    = 1'b0;
        rsp.read_data = pfb_pkg::BYTE_ZEROS;
        cols  = eff_cols();
        pages = eff_pages();
        rows  = pages * 8;
        case (r.cmd)
            pfb_pkg::CMD_FILL: begin
                for (p = 0; p < pages; p++)
                    for (c = 0; c < cols; c++)
                        store_model[p*NUM_COLS + c] = r.set_bits ? pfb_pkg::BYTE_ONES
                                                                 : pfb_pkg::BYTE_ZEROS;
            end
            pfb_pkg::CMD_RECT: begin
                if (r.x_first >= cols || r.x_last >= cols || r.y_first >= rows ||
                    r.y_last >= rows || r.x_first > r.x_last || r.y_first > r.y_last) begin
                    rsp.status = 1'b1;
                end else begin
                    for (y = r.y_first; y <= r.y_last; y++) begin
                        row_bit = 8'h01 << (y % 8);
                        for (c = r.x_first; c <= r.x_last; c++) begin
                            idx = (y / 8) * NUM_COLS + c;
                            if (r.set_bits)
                                store_model[idx] = store_model[idx] | row_bit;
                            else
                                store_model[idx] = store_model[idx] & ~row_bit;
                        end
                    end
                end
            end
            pfb_pkg::CMD_BLIT: begin
                if (r.x_first >= cols || r.y_first >= rows) begin
                    rsp.status = 1'b1;
                end else begin
                    img     = r.invert ? ~r.data_byte : r.data_byte;
                    page    = int'(r.y_first) / 8;
                    off     = int'(r.y_first) % 8;
                    shifted = {8'h00, img} << off;
                    idx     = page * NUM_COLS + int'(r.x_first);
                    if (off == 0) begin
                        store_model[idx] = img;
                    end else begin
                        store_model[idx] = store_model[idx] | shifted[7:0];
                        // spill past the last page in use is dropped
                        if (page + 1 < pages)
                            store_model[idx + NUM_COLS] = store_model[idx + NUM_COLS] |
                                                          shifted[15:8];
                    end
                end
            end
            default: begin
                if (r.x_first >= cols || r.y_first >= rows)
                    rsp.status = 1'b1;
                else
                    rsp.read_data = store_model[(int'(r.y_first) / 8) * NUM_COLS +
                                                int'(r.x_first)];
            end
        endcase
        return rsp;
    endfunction

    function automatic void add_req(input logic [1:0] cmd, input int x1, input int x2,
                                    input int y1, input int y2, input bit set_bits,
                                    input int data, input bit invert);
        draw_req_t r;
        r.cmd       = cmd;
        r.x_first   = 7'(x1);
        r.x_last    = 7'(x2);
        r.y_first   = 6'(y1);
        r.y_last    = 6'(y2);
        r.set_bits  = set_bits;
        r.data_byte = 8'(data);
        r.invert    = invert;
        pending_reqs.push_back(r);
    endfunction

    // mostly in-range, small-area requests; some wide bands and some raw noise
    function automatic draw_req_t random_req();
        draw_req_t r;
        int        cols, rows, pick, xl, yl;
        cols = (eff_cols() < 1) ? 1 : eff_cols();
        rows = (eff_pages() < 1) ? 8 : eff_pages() * 8;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            r.cmd = pfb_pkg::CMD_FILL;
        else if (pick < 38)
            r.cmd = pfb_pkg::CMD_RECT;
        else if (pick < 73)
            r.cmd = pfb_pkg::CMD_BLIT;
        else
            r.cmd = pfb_pkg::CMD_READ;
        r.x_first   = 7'($urandom_range(0, cols - 1));
        r.y_first   = 6'($urandom_range(0, rows - 1));
        xl          = int'(r.x_first) + $urandom_range(0, 7);
        yl          = int'(r.y_first) + $urandom_range(0, 9);
        r.x_last    = 7'((xl > 127) ? 127 : xl);
        r.y_last    = 6'((yl > 63) ? 63 : yl);
        r.set_bits  = 1'($urandom);
        r.data_byte = 8'($urandom);
        r.invert    = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4 && r.cmd == pfb_pkg::CMD_RECT) begin
            r.x_first = '0;
            r.x_last  = 7'(cols - 1);
        end else if (pick < 14) begin
            r.x_first = 7'($urandom);
            r.x_last  = 7'($urandom);
            r.y_first = 6'($urandom);
            r.y_last  = 6'($urandom);
        end
        return r;
    endfunction

    task automatic write_reg(input logic [pfb_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == pfb_pkg::REG_COLUMNS)
            cols_reg = val;
        else if (idx == pfb_pkg::REG_PAGES)
            pages_reg = val[3:0];
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [7:0] cols, input logic [7:0] pages);
        write_reg(pfb_pkg::REG_COLUMNS, cols);
        write_reg(pfb_pkg::REG_PAGES, pages);
        settings_used++;
    endtask

    // sender holds off until every queued request has its result back
    task automatic wait_idle(input int extra);
        @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0)
            @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    // request driver
    always @(posedge aclk) begin
        draw_req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap   <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rsps.push_back(apply_draw_req(cur_req));
                reqs_sent++;
            end
            if (!s_valid || s_ready) begin
                if (s_gap != 0) begin
                    s_valid <= 1'b0;
                    s_gap   <= s_gap - 1;
                end else if (pending_reqs.size() != 0) begin
                    r           = pending_reqs.pop_front();
                    cur_req     = r;
                    s_valid     <= 1'b1;
                    s_command   <= r.cmd;
                    s_x_first   <= r.x_first;
                    s_x_last    <= r.x_last;
                    s_y_first   <= r.y_first;
                    s_y_last    <= r.y_last;
                    s_set_bits  <= r.set_bits;
                    s_data_byte <= r.data_byte;
                    s_invert    <= r.invert;
                    s_gap       <= s_burst ? 0 : $urandom_range(0, 15);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        draw_rsp_t   exp_rsp;
        int unsigned st;
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_stall <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_rsps.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got status %0d data %02h",
                         $time, m_status, m_read_data);
            end else begin
                exp_rsp = expected_rsps.pop_front();
                rsps_checked++;
                if (m_status !== exp_rsp.status || m_read_data !== exp_rsp.read_data) begin
                    errors++;
                    $display(
                        "%0t: result %0d expected status %0d data %02h, got %0d data %02h",
                        $time, rsps_checked, exp_rsp.status, exp_rsp.read_data,
                        m_status, m_read_data);
                end
            end
            st = m_burst ? 0 : $urandom_range(0, 15);
            if (st == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                m_stall <= st - 1;
            end
        end else if (m_stall != 0) begin
            m_stall <= m_stall - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any request moving
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready) ||
                     (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int         ph, n, pick, cols_val, pages_val;
        for (n = 0; n < NUM_COLS*NUM_PAGES; n++)
            store_model[n] = pfb_pkg::BYTE_ZEROS;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // full-size store straight out of reset
        add_req(pfb_pkg::CMD_READ, 0, 0, 0, 0, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_FILL, 0, 0, 0, 0, 1'b1, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_READ, 127, 0, 63, 0, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_RECT, 0, 127, 0, 63, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_RECT, 5, 5, 13, 13, 1'b1, 8'h00, 1'b0);      // single pixel
        add_req(pfb_pkg::CMD_READ, 5, 0, 8, 0, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_BLIT, 10, 0, 16, 0, 1'b0, 8'hA5, 1'b0);      // page aligned
        add_req(pfb_pkg::CMD_BLIT, 10, 0, 19, 0, 1'b0, 8'h3C, 1'b1);      // unaligned, inverted
        add_req(pfb_pkg::CMD_BLIT, 11, 0, 61, 0, 1'b0, 8'hFF, 1'b0);      // spill off last page
        add_req(pfb_pkg::CMD_READ, 10, 0, 16, 0, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_READ, 10, 0, 24, 0, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_READ, 11, 0, 56, 0, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_BLIT, 10, 0, 16, 0, 1'b1, 8'h00, 1'b0);      // aligned overwrite
        add_req(pfb_pkg::CMD_READ, 10, 0, 16, 0, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_RECT, 9, 3, 0, 0, 1'b1, 8'h00, 1'b0);        // x reversed
        add_req(pfb_pkg::CMD_RECT, 0, 0, 20, 10, 1'b1, 8'h00, 1'b0);      // y reversed
        add_req(pfb_pkg::CMD_RECT, 126, 127, 0, 63, 1'b1, 8'hFF, 1'b1);
        add_req(pfb_pkg::CMD_READ, 127, 0, 40, 0, 1'b0, 8'h00, 1'b0);
        wait_idle(4);

        // one-column, two-page store
        set_config(8'd1, 8'd2);
        add_req(pfb_pkg::CMD_FILL, 0, 0, 0, 0, 1'b1, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_READ, 1, 0, 0, 0, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_BLIT, 0, 0, 15, 0, 1'b0, 8'h81, 1'b0);
        add_req(pfb_pkg::CMD_READ, 0, 0, 8, 0, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_RECT, 0, 0, 16, 16, 1'b0, 8'h00, 1'b0);
        wait_idle(4);

        // zero sizes: fill does nothing, everything else rejected
        set_config(8'd0, 8'd0);
        add_req(pfb_pkg::CMD_FILL, 0, 0, 0, 0, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_READ, 0, 0, 0, 0, 1'b0, 8'h00, 1'b0);
        wait_idle(4);

        // oversized width clamps, pages takes the low nibble, unused indexes ignored
        set_config(8'd200, 8'hF3);
        write_reg(REG_UNUSED_HI, 8'h00);
        write_reg(REG_UNUSED_LO, 8'hFF);
        add_req(pfb_pkg::CMD_READ, 127, 0, 23, 0, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_READ, 0, 0, 24, 0, 1'b0, 8'h00, 1'b0);
        add_req(pfb_pkg::CMD_BLIT, 127, 0, 20, 0, 1'b0, 8'h5A, 1'b0);
        wait_idle(4);

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                cols_val = $urandom_range(1, 16);
            else if (pick < 6)
                cols_val = 128;
            else if (pick == 6)
                cols_val = $urandom_range(17, 127);
            else if (pick == 7)
                cols_val = $urandom_range(129, 255);
            else if (pick == 8)
                cols_val = 0;
            else
                cols_val = $urandom_range(1, 128);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                pages_val = $urandom_range(2, 8);
            else if (pick == 7)
                pages_val = ($urandom_range(0, 1) != 0) ? 2 : 8;
            else
                pages_val = $urandom_range(0, 15);
            pages_val = pages_val | ($urandom_range(0, 15) << 4);
            set_config(8'(cols_val), 8'(pages_val));
            s_burst = ($urandom_range(0, 3) == 0);
            m_burst = ($urandom_range(0, 3) == 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                pending_reqs.push_back(random_req());
            wait_idle(4);
        end

        wait_idle(DRAIN_CYCLES);
        $display("ran %0d draw/read requests over %0d register settings, %0d results checked",
                 reqs_sent, settings_used, rsps_checked);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/pfb_pkg.sv
rtl/pfb_front.sv
rtl/pfb_cmd_fifo.sv
rtl/pfb_back.sv
rtl/page_frame_buffer_draw_engine_core.sv
bench/page_frame_buffer_draw_engine_core_tb.sv
